// File: rtl/tcd_pkg.sv
// Shared types, codes and sizes of the template coverage depth counter.
// Used by every module of the block but tcd_ram; depends on nothing else.
package tcd_pkg;

  // Default sizes of the depth store and the template store.
  localparam int REGION_LEN_DEF    = 4096;
  localparam int NUM_TEMPLATES_DEF = 1024;

  // Depth of the queue between the classifier and the executor.
  localparam int Q_DEPTH = 2;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'd1;
  localparam logic [15:0] REGION_START_RST = 16'd1;
  localparam logic [15:0] REGION_END_RST   = 16'd4096;

  // One command as it arrives.
  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  template_id;
    logic [15:0] read_position;
    logic [15:0] read_length;
    logic [11:0] depth_offset;
  } cmd_t;

  // One result as it leaves.
  typedef struct packed {
    logic [15:0] max_depth;
    logic [15:0] depth_value;
    logic [1:0]  status;
  } result_t;

  // A classified command held in the queue.
  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  pre_status;   // nonzero: finish at once with this status
    logic [9:0]  template_id;
    logic [15:0] clip_lo;      // reading clipped to the region
    logic [15:0] clip_hi;
    logic [15:0] region_lo;
    logic [11:0] depth_offset;
  } entry_t;

endpackage

// File: rtl/tcd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents when the same address is written.
module tcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcd_queue.sv
// Short queue of classified commands between the classifier and the executor.
// Depends on tcd_pkg for the entry type and the queue depth.
module tcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcd_pkg::entry_t push_entry,
  input  logic            pop,
  output tcd_pkg::entry_t head,
  output logic            not_empty,
  output logic            full
);
  import tcd_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  entry_t         slots [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CW'(Q_DEPTH));

  // Pointer that wraps at the queue depth.
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (p == PW'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/tcd_front.sv
// Front end: configuration registers and classification of each command.
// Clips readings to the region and screens out ranges; depends on tcd_pkg.
module tcd_front #(
  parameter int REGION_LEN    = tcd_pkg::REGION_LEN_DEF,
  parameter int NUM_TEMPLATES = tcd_pkg::NUM_TEMPLATES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  input  tcd_pkg::cmd_t                  cmd,
  output tcd_pkg::entry_t                entry
);
  import tcd_pkg::*;

  logic [15:0] region_start;
  logic [15:0] region_end;

  logic [16:0] lo17;
  logic [16:0] cap;
  logic [16:0] end17;
  logic [16:0] hi;
  logic [16:0] pos17;
  logic [16:0] rhi1;
  logic [16:0] rhi;
  logic [16:0] clo;
  logic [16:0] chi;
  logic        outside;
  logic        tmpl_ok;
  logic        offset_ok;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= REGION_START_RST;
      region_end   <= REGION_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_START: region_start <= cfg_data;
        REG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective region and the reading's span; rhi1 is one past its end.
  always_comb begin
    lo17      = {1'b0, region_start};
    cap       = lo17 + 17'(REGION_LEN) - 17'd1;
    end17     = {1'b0, region_end};
    hi        = (end17 < cap) ? end17 : cap;
    pos17     = {1'b0, cmd.read_position};
    rhi1      = pos17 + {1'b0, cmd.read_length};
    rhi       = rhi1 - 17'd1;
    outside   = (hi < lo17) || (pos17 > hi) || (rhi1 <= lo17);
    clo       = (pos17 < lo17) ? lo17 : pos17;
    chi       = (rhi < hi) ? rhi : hi;
    tmpl_ok   = (17'(cmd.template_id) < 17'(NUM_TEMPLATES));
    offset_ok = (17'(cmd.depth_offset) < 17'(REGION_LEN));
  end

  // Classified entry for the queue.
  always_comb begin
    entry.operation    = cmd.operation;
    entry.template_id  = cmd.template_id;
    entry.clip_lo      = clo[15:0];
    entry.clip_hi      = chi[15:0];
    entry.region_lo    = region_start;
    entry.depth_offset = cmd.depth_offset;
    unique case (cmd.operation)
      OP_ADD: begin
        if (outside) begin
          entry.pre_status = ST_OUTSIDE;
        end else if (!tmpl_ok) begin
          entry.pre_status = ST_NONE;
        end else begin
          entry.pre_status = ST_OK;
        end
      end
      OP_READ:  entry.pre_status = offset_ok ? ST_OK : ST_OUTSIDE;
      default:  entry.pre_status = ST_OK;
    endcase
  end

endmodule

// File: rtl/tcd_back.sv
// Back end: carries out queued commands against the depth and template stores.
// Holds the sequencer, both RAMs, the clearing sweep and the result register.
// Depends on tcd_pkg and tcd_ram.
module tcd_back #(
  parameter int REGION_LEN    = tcd_pkg::REGION_LEN_DEF,
  parameter int NUM_TEMPLATES = tcd_pkg::NUM_TEMPLATES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tcd_pkg::entry_t   head,
  input  logic              not_empty,
  output logic              pop,
  output logic              init_busy,
  output logic              done,
  output tcd_pkg::result_t  result
);
  import tcd_pkg::*;

  localparam int DA    = (REGION_LEN > 1) ? $clog2(REGION_LEN) : 1;
  localparam int TA    = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
  localparam int CLR_N = (REGION_LEN > NUM_TEMPLATES) ? REGION_LEN : NUM_TEMPLATES;
  localparam int CNT_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_TWAIT = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DWAIT = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t      state, state_next;
  entry_t      cur, cur_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [DA-1:0] walk_idx, walk_idx_next;
  logic [DA-1:0] walk_end, walk_end_next;
  logic [DA-1:0] rmw_addr, rmw_addr_next;
  logic          rmw_pend, rmw_pend_next;
  logic [15:0]   running_max, running_max_next;
  logic          done_next;
  result_t       result_next;

  // RAM ports.
  logic          d_we;
  logic [DA-1:0] d_waddr;
  logic [15:0]   d_wdata;
  logic [DA-1:0] d_raddr;
  logic [15:0]   d_rdata;
  logic          t_we;
  logic [TA-1:0] t_waddr;
  logic [16:0]   t_wdata;
  logic [TA-1:0] t_raddr;
  logic [16:0]   t_rdata;

  // Datapath helpers.
  logic [16:0]   head_tmpl17;
  logic [16:0]   cur_tmpl17;
  logic [16:0]   head_off17;
  logic [16:0]   cnt17;
  logic [16:0]   clo17;
  logic [16:0]   chi17;
  logic [16:0]   lo17;
  logic [16:0]   rlo;
  logic [16:0]   first_idx;
  logic [16:0]   last_idx;
  logic          nonempty;
  logic [15:0]   inc;
  logic [15:0]   max_upd;

  tcd_ram #(.WIDTH(16), .DEPTH(REGION_LEN), .AW(DA)) u_depth (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  tcd_ram #(.WIDTH(17), .DEPTH(NUM_TEMPLATES), .AW(TA)) u_tmpl (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign init_busy = (state == S_INIT);

  // Clipping against the template's next position and the counter update.
  always_comb begin
    head_tmpl17 = 17'(head.template_id);
    cur_tmpl17  = 17'(cur.template_id);
    head_off17  = 17'(head.depth_offset);
    cnt17       = 17'(cnt);
    clo17       = {1'b0, cur.clip_lo};
    chi17       = {1'b0, cur.clip_hi};
    lo17        = {1'b0, cur.region_lo};
    rlo         = (clo17 > t_rdata) ? clo17 : t_rdata;
    nonempty    = (rlo <= chi17);
    first_idx   = rlo - lo17;
    last_idx    = chi17 - lo17;
    inc         = (d_rdata == 16'hFFFF) ? d_rdata : d_rdata + 16'd1;
    max_upd     = (inc > running_max) ? inc : running_max;
  end

  // Sequencer.
  always_comb begin
    state_next       = state;
    cur_next         = cur;
    cnt_next         = cnt;
    walk_idx_next    = walk_idx;
    walk_end_next    = walk_end;
    rmw_addr_next    = rmw_addr;
    rmw_pend_next    = 1'b0;
    running_max_next = running_max;
    done_next        = 1'b0;
    result_next      = result;
    pop              = 1'b0;

    d_we    = 1'b0;
    d_waddr = rmw_addr;
    d_wdata = inc;
    d_raddr = walk_idx;
    t_we    = 1'b0;
    t_waddr = cur_tmpl17[TA-1:0];
    t_wdata = nonempty ? (chi17 + 17'd1) : rlo;
    t_raddr = head_tmpl17[TA-1:0];

    // Pending read-modify-write of a depth counter.
    if (rmw_pend) begin
      d_we             = 1'b1;
      running_max_next = max_upd;
    end

    unique case (state)
      S_INIT, S_CLEAR: begin
        d_we    = (cnt17 < 17'(REGION_LEN));
        d_waddr = cnt[DA-1:0];
        d_wdata = '0;
        t_we    = (cnt17 < 17'(NUM_TEMPLATES));
        t_waddr = cnt[TA-1:0];
        t_wdata = '0;
        running_max_next = '0;
        if (cnt == CNT_W'(CLR_N - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
          if (state == S_CLEAR) begin
            done_next   = 1'b1;
            result_next = '{max_depth: 16'd0, depth_value: 16'd0, status: ST_OK};
          end
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_IDLE: begin
        d_raddr = head_off17[DA-1:0];
        if (not_empty) begin
          pop      = 1'b1;
          cur_next = head;
          if (head.pre_status != ST_OK || head.operation == OP_NOP) begin
            done_next   = 1'b1;
            result_next = '{max_depth: running_max, depth_value: 16'd0,
                            status: head.pre_status};
          end else begin
            unique case (head.operation)
              OP_ADD:   state_next = S_TWAIT;
              OP_READ:  state_next = S_DWAIT;
              OP_CLEAR: state_next = S_CLEAR;
              default:  state_next = S_IDLE;
            endcase
          end
        end
      end
      S_TWAIT: begin
        // The template's next position is in; store the new one.
        t_we = 1'b1;
        if (nonempty) begin
          walk_idx_next = first_idx[DA-1:0];
          walk_end_next = last_idx[DA-1:0];
          state_next    = S_WALK;
        end else begin
          done_next   = 1'b1;
          result_next = '{max_depth: running_max, depth_value: 16'd0, status: ST_NONE};
          state_next  = S_IDLE;
        end
      end
      S_WALK: begin
        // Read one counter a cycle; its increment is written the next cycle.
        rmw_pend_next = 1'b1;
        rmw_addr_next = walk_idx;
        if (walk_idx == walk_end) begin
          state_next = S_DRAIN;
        end else begin
          walk_idx_next = walk_idx + DA'(1);
        end
      end
      S_DRAIN: begin
        done_next   = 1'b1;
        result_next = '{max_depth: max_upd, depth_value: 16'd0, status: ST_OK};
        state_next  = S_IDLE;
      end
      S_DWAIT: begin
        done_next   = 1'b1;
        result_next = '{max_depth: running_max, depth_value: d_rdata, status: ST_OK};
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      rmw_pend    <= 1'b0;
      running_max <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      rmw_pend    <= rmw_pend_next;
      running_max <= running_max_next;
      done        <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    walk_idx <= walk_idx_next;
    walk_end <= walk_end_next;
    rmw_addr <= rmw_addr_next;
    result   <= result_next;
  end

endmodule

// File: rtl/template_coverage_depth.sv
// Template coverage depth counter: top level, classifier, queue and executor.
// Two commands wait in the queue; busy is high while it is full and during the
// clearing sweep of both RAMs after reset. The receiver cannot stall results.
module template_coverage_depth #(
  parameter int REGION_LEN    = tcd_pkg::REGION_LEN_DEF,
  parameter int NUM_TEMPLATES = tcd_pkg::NUM_TEMPLATES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tcd_pkg::cmd_t                  cmd,
  input  logic                           cfg_we,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           done,
  output tcd_pkg::result_t               result
);
  import tcd_pkg::*;

  entry_t entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   not_empty;
  logic   full;
  logic   init_busy;

  // A command transfer happens when start meets busy low: a free queue slot and no sweep after reset.
  assign busy = full || init_busy;
  assign push = start && !busy;

  tcd_front #(.REGION_LEN(REGION_LEN), .NUM_TEMPLATES(NUM_TEMPLATES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .entry     (entry)
  );

  tcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  tcd_back #(.REGION_LEN(REGION_LEN), .NUM_TEMPLATES(NUM_TEMPLATES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .done      (done),
    .result    (result)
  );

endmodule

// File: verif/tb_template_coverage_depth.sv
`timescale 1ns / 1ps
// Self-checking testbench for the template coverage depth counter.
// Depends on tcd_pkg and template_coverage_depth; runs directed and random commands.
module tb_template_coverage_depth;
  import tcd_pkg::*;

  localparam int DEPTH_LEN = REGION_LEN_DEF;
  localparam int TMPL_COUNT = NUM_TEMPLATES_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  // This covers every command being as slow as a clear or a full-region reading
  // about ten times over.
  localparam longint TIMEOUT_NS = 400_000_000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 done;
  result_t              result;

  template_coverage_depth dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  // Expected contents of the block's stores and registers.
  logic [15:0] depth_store [DEPTH_LEN];
  logic [16:0] tmpl_next [TMPL_COUNT];
  logic [15:0] peak_depth;
  logic [15:0] region_lo;
  logic [15:0] region_hi;

  result_t pending_results[$];
  int      mismatches;
  int      sender_idle_pct;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // Empties the depth counters, the template positions and the peak.
  function automatic void clear_coverage();
    for (int i = 0; i < DEPTH_LEN; i++) depth_store[i] = '0;
    for (int i = 0; i < TMPL_COUNT; i++) tmpl_next[i] = '0;
    peak_depth = '0;
  endfunction

  // Counts one reading into the depth counters and returns its status.
  function automatic logic [1:0] count_reading(logic [9:0] tmpl, logic [15:0] pos,
                                               logic [15:0] len);
    int lo;
    int hi;
    int cap;
    int r_lo;
    int r_hi;
    int p;
    lo = int'(region_lo);
    hi = int'(region_hi);
    cap = lo + DEPTH_LEN - 1;
    r_lo = int'(pos);
    r_hi = int'(pos) + int'(len) - 1;
    if (hi > cap) hi = cap;
    if (hi < lo || r_lo > hi || r_hi < lo) return ST_OUTSIDE;
    if (int'(tmpl) >= TMPL_COUNT) return ST_NONE;
    // Clip to the region, then skip what this template already covered.
    if (r_lo < lo) r_lo = lo;
    if (r_hi > hi) r_hi = hi;
    if (r_lo < int'(tmpl_next[tmpl])) r_lo = int'(tmpl_next[tmpl]);
    for (p = r_lo; p <= r_hi; p++) begin
      if (depth_store[p - lo] != 16'hFFFF) depth_store[p - lo]++;
      if (depth_store[p - lo] > peak_depth) peak_depth = depth_store[p - lo];
    end
    tmpl_next[tmpl] = 17'(p);
    return (r_lo <= r_hi) ? ST_OK : ST_NONE;
  endfunction

  // Works out the result of one command and updates the expected state.
  function automatic result_t predict_command(cmd_t c);
    result_t r;
    r.depth_value = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_ADD: begin
        r.status = count_reading(c.template_id, c.read_position, c.read_length);
      end
      OP_READ: begin
        if (int'(c.depth_offset) < DEPTH_LEN) r.depth_value = depth_store[c.depth_offset];
        else r.status = ST_OUTSIDE;
      end
      OP_CLEAR: begin
        clear_coverage();
      end
      default: ;
    endcase
    r.max_depth = peak_depth;
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, logic [9:0] tmpl, logic [15:0] pos,
                                    logic [15:0] len, logic [11:0] off);
    cmd_t c;
    c.operation = op;
    c.template_id = tmpl;
    c.read_position = pos;
    c.read_length = len;
    c.depth_offset = off;
    return c;
  endfunction

  // Sends one command, with an optional idle gap first, and records its result.
  task automatic send_cmd(input cmd_t c);
    logic busy_seen;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    // The transfer happens at the first edge with busy low.
    do begin
      @(negedge clk);
      busy_seen = busy;
      @(posedge clk);
    end while (busy_seen !== 1'b0);
    pending_results.push_back(predict_command(c));
  endtask

  // Waits until every result is in and the block is idle again.
  task automatic wait_drained();
    logic busy_seen;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    do begin
      @(negedge clk);
      busy_seen = busy;
      @(posedge clk);
    end while (busy_seen !== 1'b0);
  endtask

  // Programs both region bounds while the block is idle.
  task automatic set_region(input logic [15:0] lo, input logic [15:0] hi);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_REGION_END;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    region_lo = lo;
    region_hi = hi;
  endtask

  // Overlap clipping, zero lengths, field extremes and every operation,
  // with the reset region.
  task automatic test_clipping_basics();
    sender_idle_pct = 0;
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd0, 16'd1, 16'd10, 12'd0));
    // Same template again: only the part past its last counted position counts.
    send_cmd(make_cmd(OP_ADD, 10'd0, 16'd5, 16'd10, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd0, 16'd3, 16'd5, 12'd0));
    // Zero-length readings, one ending before the region and one inside it.
    send_cmd(make_cmd(OP_ADD, 10'd1, 16'd1, 16'd0, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd1, 16'd4, 16'd0, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd2, 16'd3, 16'd4, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'h3FF, 16'd4096, 16'hFFFF, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd3, 16'hFFFF, 16'hFFFF, 12'd0));
    // A reading over the whole region.
    send_cmd(make_cmd(OP_ADD, 10'd4, 16'd1, 16'hFFFF, 12'd0));
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'd4));
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'hFFF));
    send_cmd(make_cmd(OP_NOP, 10'h3FF, 16'hFFFF, 16'hFFFF, 12'hFFF));
    send_cmd(make_cmd(OP_CLEAR, 10'd0, 16'd1, 16'd0, 12'd0));
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'd4));
    // After a clear the template may count from the start again.
    send_cmd(make_cmd(OP_ADD, 10'd0, 16'd2, 16'd3, 12'd0));
  endtask

  // Empty, oversized and top-of-range regions.
  task automatic test_region_limits();
    set_region(16'd3000, 16'd2999);
    send_cmd(make_cmd(OP_ADD, 10'd5, 16'd1, 16'hFFFF, 12'd0));
    set_region(16'd1, 16'hFFFF);
    send_cmd(make_cmd(OP_ADD, 10'd6, 16'd4000, 16'd200, 12'd0));
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'hFFF));
    set_region(16'hFFFF, 16'hFFFF);
    send_cmd(make_cmd(OP_ADD, 10'd7, 16'hFFFF, 16'd1, 12'd0));
    send_cmd(make_cmd(OP_ADD, 10'd7, 16'hFFFF, 16'd1, 12'd0));
    send_cmd(make_cmd(OP_READ, 10'd0, 16'd1, 16'd0, 12'd0));
  endtask

  // One region setting: readings in position order from a moving cursor,
  // mixed with depth reads, out-of-order readings and random noise.
  task automatic run_random_phase(input int lo, input int hi, input int count,
                                  input int idle_pct);
    int   eff_hi;
    int   top;
    int   step;
    int   cursor;
    int   pool_base;
    int   roll;
    int   pos;
    int   len;
    cmd_t c;
    set_region(16'(lo), 16'(hi));
    sender_idle_pct = idle_pct;
    eff_hi = (hi > lo + DEPTH_LEN - 1) ? lo + DEPTH_LEN - 1 : hi;
    top = (eff_hi >= lo) ? eff_hi : lo;
    step = (top - lo) / 100 + 3;
    cursor = (lo > 300) ? lo - 300 : 1;
    pool_base = int'($urandom_range(0, TMPL_COUNT - 16));
    for (int i = 0; i < count; i++) begin
      roll = int'($urandom_range(0, 99));
      c = make_cmd(OP_ADD, 10'($urandom_range(0, TMPL_COUNT - 1)),
                   16'($urandom_range(1, 65535)), 16'($urandom), 12'($urandom));
      if (roll < 8) begin
        c.operation = 2'($urandom);
      end else if (roll < 22) begin
        // Depth reads, mostly near the positions being counted.
        c.operation = OP_READ;
        if (roll < 18) c.depth_offset = 12'(cursor - lo + int'($urandom_range(0, 300)) - 150);
      end else begin
        if (roll < 25) pos = cursor - int'($urandom_range(0, 500));
        else pos = cursor + int'($urandom_range(0, step));
        if (pos < 1) pos = 1;
        if (pos > 65535) pos = 65535;
        if ($urandom_range(0, 49) == 0) len = int'($urandom_range(300, DEPTH_LEN));
        else len = int'($urandom_range(0, 300));
        c.read_position = 16'(pos);
        c.read_length = 16'(len);
        // Half the readings come from a small set of templates so they overlap.
        if ($urandom_range(0, 1) == 1) begin
          c.template_id = 10'(pool_base + int'($urandom_range(0, 15)));
        end
        if (roll >= 25) cursor += int'($urandom_range(0, step));
      end
      send_cmd(c);
      // Past the region, start over; sometimes from empty stores.
      if (cursor > top + 50) begin
        cursor = (lo > 300) ? lo - 300 : 1;
        if ($urandom_range(0, 2) == 0) send_cmd(make_cmd(OP_CLEAR, '0, 16'd1, '0, '0));
      end
    end
  endtask

  task automatic test_random_readings();
    run_random_phase(1, 4096, 250, 0);
    run_random_phase(100, 2000, 200, 67);
    run_random_phase(1, 65535, 200, 7);
    run_random_phase(65535, 65535, 80, 0);
    run_random_phase(60000, 65535, 200, 67);
    run_random_phase(3000, 2999, 60, 7);
    run_random_phase(1, 1, 80, 67);
    run_random_phase(1, 4096, 100, 7);
  endtask

  // Compares each result transfer with the oldest expectation.
  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("result with nothing expected: %p", result);
      end else begin
        want = pending_results.pop_front();
        if (result.max_depth !== want.max_depth || result.depth_value !== want.depth_value ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display({"mismatch at %0t: max_depth exp %0d got %0d, ",
                      "depth_value exp %0d got %0d, status exp %0d got %0d"},
                     $realtime, want.max_depth, result.max_depth, want.depth_value,
                     result.depth_value, want.status, result.status);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mismatches = 0;
    sender_idle_pct = 0;
    region_lo = REGION_START_RST;
    region_hi = REGION_END_RST;
    clear_coverage();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_clipping_basics();
    test_region_limits();
    test_random_readings();
    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
